// File: src/pulse_source_waveform_defines.svh
// Assertion macros shared by the checker of the pulse source.
// No dependencies.
`ifndef PULSE_SOURCE_WAVEFORM_DEFINES_SVH
`define PULSE_SOURCE_WAVEFORM_DEFINES_SVH

// Assert that an antecedent implies a consequent in the next cycle.
`define PSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

// Assert that an antecedent implies a consequent in the same cycle.
`define PSW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

`endif

// File: src/psw_pkg.sv
// Package of the pulse source: widths and register indexes.
// No dependencies.
package psw_pkg;
    localparam int TimeBits  = 32;
    localparam int LevelBits = 24;
    localparam int StepBits  = 16;
    localparam int CountBits = 16;
    localparam int CfgBits   = 32;
    localparam int IdxBits   = 3;
    localparam int MagBits   = LevelBits + 1;
    localparam int ProdBits  = TimeBits + MagBits;

    localparam logic [IdxBits-1:0] RegLow    = 3'd0;
    localparam logic [IdxBits-1:0] RegHigh   = 3'd1;
    localparam logic [IdxBits-1:0] RegDelay  = 3'd2;
    localparam logic [IdxBits-1:0] RegRise   = 3'd3;
    localparam logic [IdxBits-1:0] RegFall   = 3'd4;
    localparam logic [IdxBits-1:0] RegOn     = 3'd5;
    localparam logic [IdxBits-1:0] RegPeriod = 3'd6;
    localparam logic [IdxBits-1:0] RegCycles = 3'd7;

    typedef struct packed {
        logic signed [LevelBits-1:0] level;
    } out_item_t;

    typedef struct packed {
        logic [TimeBits-1:0] time_point;
        logic [StepBits-1:0] time_step;
    } in_item_t;
endpackage

// File: src/psw_if.sv
// Valid/ready channel interfaces of the pulse source.
// Depends on psw_pkg.
interface psw_in_if;
    logic valid;
    logic ready;
    logic [psw_pkg::TimeBits-1:0] time_point;
    logic [psw_pkg::StepBits-1:0] time_step;
    modport source (output valid, time_point, time_step, input ready);
    modport sink (input valid, time_point, time_step, output ready);
endinterface

interface psw_out_if;
    logic valid;
    logic ready;
    logic signed [psw_pkg::LevelBits-1:0] level;
    modport source (output valid, level, input ready);
    modport sink (input valid, level, output ready);
endinterface

// File: src/psw_divider.sv
// Pipelined restoring divider: a ProdBits numerator by a TimeBits divisor,
// four quotient bits per stage; depends on psw_pkg.
module psw_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [psw_pkg::ProdBits-1:0]  num,
    input  logic [psw_pkg::TimeBits-1:0]  den,
    output logic [psw_pkg::ProdBits-1:0]  quo,
    output logic [psw_pkg::TimeBits-1:0]  rem
);
    localparam int NBits  = psw_pkg::ProdBits;
    localparam int DBits  = psw_pkg::TimeBits;
    localparam int Per    = 4;
    localparam int Stages = (NBits + Per - 1) / Per;
    localparam int NPad   = Stages * Per;

    for (genvar s = 0; s < Stages; s++) begin : g_stage
        logic [NPad-1:0]  q_reg;
        logic [DBits:0]   r_reg;
        logic [DBits-1:0] d_reg;
        logic [NPad-1:0]  q_in;
        logic [DBits:0]   r_in;
        logic [DBits-1:0] d_in;
        logic [NPad-1:0]  q_next;
        logic [DBits:0]   r_next;

        // Pad the numerator with leading zeros up to a whole number of stages.
        if (s == 0) begin : g_first
            assign q_in = NPad'(num);
            assign r_in = '0;
            assign d_in = den;
        end else begin : g_rest
            assign q_in = g_stage[s-1].q_reg;
            assign r_in = g_stage[s-1].r_reg;
            assign d_in = g_stage[s-1].d_reg;
        end

        always_comb
        begin
            q_next = q_in;
            r_next = r_in;
            for (int k = 0; k < Per; k++) begin
                r_next = {r_next[DBits-1:0], q_next[NPad-1]};
                q_next = {q_next[NPad-2:0], 1'b0};
                if (r_next >= {1'b0, d_in}) begin
                    r_next = r_next - {1'b0, d_in};
                    q_next[0] = 1'b1;
                end
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                q_reg <= '0;
                r_reg <= '0;
                d_reg <= '0;
            end else if (advance) begin
                q_reg <= q_next;
                r_reg <= r_next;
                d_reg <= d_in;
            end
        end
    end

    assign quo = g_stage[Stages-1].q_reg[NBits-1:0];
    assign rem = g_stage[Stages-1].r_reg[DBits-1:0];
endmodule

// File: src/pulse_source_waveform.sv
// Pulse source waveform: top level with configuration registers and pipeline.
// Depends on psw_pkg, psw_if and psw_divider.
//
// Usage:
//   in  : one transfer carries time_point and time_step. An item may enter
//         every cycle; ready is low only while the output is stalled.
//   out : one transfer carries level, the source value at that time.
//   cfg : cfg_we/cfg_index/cfg_data write the registers of the pulse
//         (low, high, delay, rise, fall, on, period, cycle limit). Write
//         only while no item is in flight.
// Pipeline: an input transfer passes the delay offset register, the period
// divider, the product register, the scaling divider and the output level
// register before output valid; throughput one item per cycle while the
// output is not stalled, set by the fully pipelined dividers.
// Stall: the whole pipeline holds while the output register is full and
// not taken; nothing is dropped or repeated.
// Reset: registers take low = high = 0, delay = rise = fall = on = 0,
// period = 1, cycle limit = 0; all valid bits clear.
module pulse_source_waveform (
    input  logic                         clk,
    input  logic                         rst_n,
    psw_in_if.sink                       in_ch,
    psw_out_if.source                    out_ch,
    input  logic                         cfg_we,
    input  logic [psw_pkg::IdxBits-1:0]  cfg_index,
    input  logic [psw_pkg::CfgBits-1:0]  cfg_data
);
    localparam int TB = psw_pkg::TimeBits;
    localparam int LB = psw_pkg::LevelBits;
    localparam int PB = psw_pkg::ProdBits;
    localparam int DivLat = (PB + 3) / 4;
    localparam int Lat = 2 * DivLat + 3;
    localparam int MagBitsL = psw_pkg::MagBits;

    // Phase of the time within a period.
    localparam logic [1:0] PhLow  = 2'd0;
    localparam logic [1:0] PhRise = 2'd1;
    localparam logic [1:0] PhHigh = 2'd2;
    localparam logic [1:0] PhFall = 2'd3;

    logic signed [LB-1:0] low_reg, high_reg;
    logic [TB-1:0] delay_reg, rise_reg, fall_reg, on_reg, period_reg;
    logic [psw_pkg::CountBits-1:0] cycles_reg;

    // Hold configuration; the user must write it only while idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            low_reg <= '0; high_reg <= '0; delay_reg <= '0; rise_reg <= '0;
            fall_reg <= '0; on_reg <= '0; period_reg <= TB'(1); cycles_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                psw_pkg::RegLow:    low_reg <= cfg_data[LB-1:0];
                psw_pkg::RegHigh:   high_reg <= cfg_data[LB-1:0];
                psw_pkg::RegDelay:  delay_reg <= cfg_data[TB-1:0];
                psw_pkg::RegRise:   rise_reg <= cfg_data[TB-1:0];
                psw_pkg::RegFall:   fall_reg <= cfg_data[TB-1:0];
                psw_pkg::RegOn:     on_reg <= cfg_data[TB-1:0];
                psw_pkg::RegPeriod: period_reg <= cfg_data[TB-1:0];
                psw_pkg::RegCycles: cycles_reg <= cfg_data[psw_pkg::CountBits-1:0];
                default: ;
            endcase
        end
    end

    // Advance all stages unless the output holds an untaken result.
    logic advance;
    logic [Lat-1:0] vld_reg;
    assign advance = !vld_reg[Lat-1] || out_ch.ready;
    assign in_ch.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= '0;
        else if (advance) vld_reg <= {vld_reg[Lat-2:0], in_ch.valid};
    end

    // Stage 0: offset from delay, edge substitution.
    logic [TB-1:0] inner_reg, rise0_reg, fall0_reg;
    logic          pre_reg;
    logic [psw_pkg::StepBits-1:0] stp;
    assign stp = (in_ch.time_step == '0) ? psw_pkg::StepBits'(1) : in_ch.time_step;
    always_ff @(posedge clk)
    begin
        if (advance) begin
            pre_reg   <= in_ch.time_point < delay_reg;
            inner_reg <= in_ch.time_point - delay_reg;
            rise0_reg <= (rise_reg == '0) ? TB'(stp) : rise_reg;
            fall0_reg <= (fall_reg == '0) ? TB'(stp) : fall_reg;
        end
    end

    // Divider 1: period count and phase.
    logic [PB-1:0] q1;
    logic [TB-1:0] r1, per;
    assign per = (period_reg == '0) ? TB'(1) : period_reg;
    psw_divider u_div_period (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .num(PB'(inner_reg)), .den(per), .quo(q1), .rem(r1)
    );

    // Delay side information alongside divider 1.
    logic [TB-1:0] rd1_reg [DivLat], fd1_reg [DivLat];
    logic          pd1_reg [DivLat];
    always_ff @(posedge clk)
    begin
        if (advance) begin
            rd1_reg[0] <= rise0_reg; fd1_reg[0] <= fall0_reg; pd1_reg[0] <= pre_reg;
            for (int i = 1; i < DivLat; i++) begin
                rd1_reg[i] <= rd1_reg[i-1]; fd1_reg[i] <= fd1_reg[i-1];
                pd1_reg[i] <= pd1_reg[i-1];
            end
        end
    end

    // Stage: phase select, numerator and denominator for the scaling divide.
    logic [TB-1:0] r_e, f_e;
    logic [TB+1:0] t3, t4;
    logic [1:0]    ph;
    logic [TB-1:0] pnum, pden;
    logic signed [LB:0] diff;
    logic [MagBitsL-1:0] mag;
    assign r_e = rd1_reg[DivLat-1];
    assign f_e = fd1_reg[DivLat-1];
    assign t3 = {2'b0, r_e} + {2'b0, on_reg};
    assign t4 = t3 + {2'b0, f_e};
    assign diff = {high_reg[LB-1], high_reg} - {low_reg[LB-1], low_reg};
    assign mag = diff[LB] ? MagBitsL'(-diff) : MagBitsL'(diff);
    always_comb
    begin
        ph = PhLow; pnum = '0; pden = r_e;
        if (!pd1_reg[DivLat-1] && q1 < PB'(cycles_reg)) begin
            if ({2'b0, r1} <= {2'b0, r_e}) begin
                ph = PhRise; pnum = r1;
            end else if ({2'b0, r1} <= t3) begin
                ph = PhHigh;
            end else if ({2'b0, r1} < t4) begin
                ph = PhFall; pnum = TB'({2'b0, r1} - t3); pden = f_e;
            end
        end
    end

    logic [PB-1:0] prod_reg;
    logic [TB-1:0] den_reg;
    logic [1:0]    ph_reg;
    always_ff @(posedge clk)
    begin
        if (advance) begin
            prod_reg <= PB'(pnum) * PB'(mag);
            den_reg  <= pden;
            ph_reg   <= ph;
        end
    end

    // Divider 2: scaled increment.
    logic [PB-1:0] q2;
    logic [TB-1:0] r2_unused;
    psw_divider u_div_scale (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .num(prod_reg), .den(den_reg), .quo(q2), .rem(r2_unused)
    );
    logic [1:0] ph2_reg [DivLat];
    always_ff @(posedge clk)
    begin
        if (advance) begin
            ph2_reg[0] <= ph_reg;
            for (int i = 1; i < DivLat; i++) ph2_reg[i] <= ph2_reg[i-1];
        end
    end

    // Output stage: apply the signed increment.
    logic signed [LB:0] inc;
    logic signed [LB-1:0] lvl_next, lvl_reg;
    assign inc = diff[LB] ? -$signed(q2[LB:0]) : $signed(q2[LB:0]);
    always_comb
    begin
        case (ph2_reg[DivLat-1])
            PhRise:  lvl_next = LB'({low_reg[LB-1], low_reg} + inc);
            PhHigh:  lvl_next = high_reg;
            PhFall:  lvl_next = LB'({high_reg[LB-1], high_reg} - inc);
            default: lvl_next = low_reg;
        endcase
    end
    always_ff @(posedge clk)
    begin
        if (advance) lvl_reg <= lvl_next;
    end

    assign out_ch.valid = vld_reg[Lat-1];
    assign out_ch.level = lvl_reg;
endmodule

// File: src/psw_checker.sv
// Port checker of the pulse source, bound to the top level.
// Depends on pulse_source_waveform_defines.svh and psw_pkg.
`include "pulse_source_waveform_defines.svh"
module psw_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [psw_pkg::LevelBits-1:0] level
);
    `PSW_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(level))
    `PSW_ASSERT_NOW(a_ready, !out_valid, in_ready)
    `PSW_ASSERT_NOW(a_stall, out_valid && !out_ready, !in_ready)
endmodule

bind pulse_source_waveform psw_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .level(out_ch.level)
);
